// ===== hw/rtl/bahc_pkg.sv =====
// shared types and constants of the block access heat counter
package bahc_pkg;

  // field widths of the channels and the configuration register
  localparam int OPCODE_W  = 2;
  localparam int OFFSET_W  = 22;
  localparam int LENGTH_W  = 23;
  localparam int QBLK_W    = 10;
  localparam int CHUNK_W   = 23;
  localparam int STATUS_W  = 2;
  localparam int FIRST_W   = 10;
  localparam int TOUCHED_W = 11;
  localparam int TOTAL_W   = 32;

  // byte end of a range: offset plus length
  localparam int END_W = 24;
  // block index carried between front and back, wide enough for the largest store
  localparam int BLK_W = 16;

  localparam logic [OPCODE_W-1:0] OP_READ  = 2'd0;
  localparam logic [OPCODE_W-1:0] OP_WRITE = 2'd1;
  localparam logic [OPCODE_W-1:0] OP_QUERY = 2'd2;

  localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_RANGE_BAD = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_QUERY_BAD = 2'd2;

  // work the back end has to do for one item
  typedef enum logic [1:0] {
    CMD_REPORT,
    CMD_READ,
    CMD_WRITE,
    CMD_QUERY
  } cmd_e;

  typedef struct packed {
    cmd_e                   cmd;
    logic [STATUS_W-1:0]    status;
    logic [FIRST_W-1:0]     first_block;
    logic [TOUCHED_W-1:0]   touched;
    logic [BLK_W-1:0]       first;
    logic [BLK_W-1:0]       last;
  } bahc_cmd_t;

  typedef enum logic [2:0] {
    BK_CLEAR,
    BK_IDLE,
    BK_WALK,
    BK_QUERY,
    BK_EMIT
  } back_state_e;

endpackage

// ===== hw/rtl/bahc_intf.sv =====
// channel interfaces of the block access heat counter
interface bahc_in_if import bahc_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [OPCODE_W-1:0] opcode;
  logic [OFFSET_W-1:0] byte_offset;
  logic [LENGTH_W-1:0] byte_length;
  logic [QBLK_W-1:0]   query_block;

  modport source (
    output valid, opcode, byte_offset, byte_length, query_block,
    input  ready
  );
  modport sink (
    input  valid, opcode, byte_offset, byte_length, query_block,
    output ready
  );
endinterface

interface bahc_out_if import bahc_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [STATUS_W-1:0]  status;
  logic [FIRST_W-1:0]   first_block;
  logic [TOUCHED_W-1:0] blocks_touched;
  logic [TOTAL_W-1:0]   read_total;
  logic [TOTAL_W-1:0]   write_total;

  modport source (
    output valid, status, first_block, blocks_touched, read_total, write_total,
    input  ready
  );
  modport sink (
    input  valid, status, first_block, blocks_touched, read_total, write_total,
    output ready
  );
endinterface

// ===== hw/rtl/bahc_front.sv =====
// front end: accepts items, checks ranges and turns them into back end commands
module bahc_front import bahc_pkg::*; #(
  parameter int BLOCK_BYTES_LOG2 = 12,
  parameter int MAX_BLOCKS       = 1024
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [CHUNK_W-1:0] chunk_bytes_i,
  input  logic               clear_busy_i,
  bahc_in_if.sink            in_i,
  output logic               push_valid_o,
  output bahc_cmd_t          push_cmd_o,
  input  logic               push_ready_i
);

  localparam int BLOCK_BYTES = 1 << BLOCK_BYTES_LOG2;

  logic                s1_valid_q, s1_valid_d;
  logic [OPCODE_W-1:0] s1_op_q;
  logic [OFFSET_W-1:0] s1_off_q;
  logic                s1_len_zero_q;
  logic [QBLK_W-1:0]   s1_qblk_q;
  logic [END_W-1:0]    s1_end_q;
  logic [END_W-1:0]    s1_endm1_q;
  logic [END_W-1:0]    nblk_q, nblk_d;
  logic                in_beat;

  logic [OFFSET_W-1:0] first_full;
  logic [END_W-1:0]    last_full;
  logic [END_W-1:0]    span;
  logic                range_bad;
  logic                last_bad;
  logic                qblk_bad;

  assign in_i.ready = !clear_busy_i && (!s1_valid_q || push_ready_i);
  assign in_beat    = in_i.valid && in_i.ready;

  // block count of the chunk, rounded up; the cap is applied at the compare
  assign nblk_d = (END_W'(chunk_bytes_i) + END_W'(BLOCK_BYTES - 1)) >> BLOCK_BYTES_LOG2;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_beat) begin
      s1_valid_d = 1'b1;
    end else if (push_ready_i) begin
      s1_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      nblk_q     <= '0;
    end else begin
      s1_valid_q <= s1_valid_d;
      nblk_q     <= nblk_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_beat) begin
      s1_op_q       <= in_i.opcode;
      s1_off_q      <= in_i.byte_offset;
      s1_len_zero_q <= (in_i.byte_length == '0);
      s1_qblk_q     <= in_i.query_block;
      s1_end_q      <= END_W'(in_i.byte_offset) + END_W'(in_i.byte_length);
      s1_endm1_q    <= END_W'(in_i.byte_offset) + END_W'(in_i.byte_length) - END_W'(1);
    end
  end

  assign first_full = s1_off_q >> BLOCK_BYTES_LOG2;
  assign last_full  = s1_endm1_q >> BLOCK_BYTES_LOG2;
  assign span       = last_full - END_W'(first_full) + END_W'(1);
  assign range_bad  = s1_end_q > END_W'(chunk_bytes_i);
  assign last_bad   = last_full >= END_W'(MAX_BLOCKS);
  assign qblk_bad   = (END_W'(s1_qblk_q) >= nblk_q) || (END_W'(s1_qblk_q) >= END_W'(MAX_BLOCKS));

  always_comb begin
    push_cmd_o = '{
      cmd:         CMD_REPORT,
      status:      STATUS_OK,
      first_block: FIRST_W'(first_full),
      touched:     '0,
      first:       BLK_W'(first_full),
      last:        BLK_W'(last_full)
    };
    case (s1_op_q) inside
      OP_READ, OP_WRITE: begin
        if (range_bad || (!s1_len_zero_q && last_bad)) begin
          push_cmd_o.status = STATUS_RANGE_BAD;
        end else if (!s1_len_zero_q) begin
          push_cmd_o.cmd     = (s1_op_q == OP_WRITE) ? CMD_WRITE : CMD_READ;
          push_cmd_o.touched = TOUCHED_W'(span);
        end
      end
      default: begin
        push_cmd_o.first_block = s1_qblk_q;
        push_cmd_o.first       = BLK_W'(s1_qblk_q);
        push_cmd_o.last        = BLK_W'(s1_qblk_q);
        if (qblk_bad) begin
          push_cmd_o.status = STATUS_QUERY_BAD;
        end else begin
          push_cmd_o.cmd = CMD_QUERY;
        end
      end
    endcase
  end

  assign push_valid_o = s1_valid_q;

endmodule

// ===== hw/rtl/bahc_queue.sv =====
// two-entry command queue between front and back end
module bahc_queue import bahc_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_valid_i,
  input  bahc_cmd_t push_cmd_i,
  output logic      push_ready_o,
  output logic      pop_valid_o,
  output bahc_cmd_t pop_cmd_o,
  input  logic      pop_i
);

  bahc_cmd_t  entry_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;
  logic       push;

  assign push_ready_o = (count_q != 2'd2);
  assign pop_valid_o  = (count_q != 2'd0);
  assign pop_cmd_o    = entry_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q ^ push;
    rd_ptr_d = rd_ptr_q ^ pop_i;
    count_d  = count_q + 2'(push) - 2'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= push_cmd_i;
    end
  end

endmodule

// ===== hw/rtl/bahc_back.sv =====
// back end: counter stores, block walk with read-modify-write, result register
module bahc_back import bahc_pkg::*; #(
  parameter int MAX_BLOCKS = 1024,
  parameter int COUNT_BITS = 32
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      q_valid_i,
  input  bahc_cmd_t q_cmd_i,
  output logic      q_pop_o,
  output logic      clear_busy_o,
  bahc_out_if.source out_o
);

  localparam int IDX_W = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;

  back_state_e state_q, state_d;
  logic [IDX_W-1:0] clr_idx_q, clr_idx_d;
  logic [IDX_W-1:0] cur_q, cur_d;
  logic [IDX_W-1:0] head_first;
  logic [IDX_W-1:0] head_last;

  logic [COUNT_BITS-1:0] rd_mem [MAX_BLOCKS];
  logic [COUNT_BITS-1:0] wr_mem [MAX_BLOCKS];
  logic [COUNT_BITS-1:0] rd_rdata_q;
  logic [COUNT_BITS-1:0] wr_rdata_q;
  logic [COUNT_BITS-1:0] sel_data;
  logic [COUNT_BITS-1:0] bumped;
  logic [COUNT_BITS-1:0] mem_wdata;
  logic [IDX_W-1:0]      mem_raddr;
  logic [IDX_W-1:0]      mem_waddr;
  logic                  rd_we;
  logic                  wr_we;

  logic [TOTAL_W-1:0] tot_rd_q, tot_rd_d;
  logic [TOTAL_W-1:0] tot_wr_q, tot_wr_d;
  logic               out_valid_q, out_valid_d;
  logic               load_out;

  assign head_first   = q_cmd_i.first[IDX_W-1:0];
  assign head_last    = q_cmd_i.last[IDX_W-1:0];
  assign clear_busy_o = (state_q == BK_CLEAR);

  assign sel_data = (q_cmd_i.cmd == CMD_WRITE) ? wr_rdata_q : rd_rdata_q;
  // counters stick at all ones
  assign bumped   = (&sel_data) ? sel_data : sel_data + COUNT_BITS'(1);

  always_comb begin
    state_d   = state_q;
    clr_idx_d = clr_idx_q;
    cur_d     = cur_q;
    tot_rd_d  = tot_rd_q;
    tot_wr_d  = tot_wr_q;
    mem_raddr = cur_q;
    mem_waddr = cur_q;
    mem_wdata = bumped;
    rd_we     = 1'b0;
    wr_we     = 1'b0;
    q_pop_o   = 1'b0;
    load_out  = 1'b0;
    unique case (state_q)
      BK_CLEAR: begin
        mem_waddr = clr_idx_q;
        mem_wdata = '0;
        rd_we     = 1'b1;
        wr_we     = 1'b1;
        clr_idx_d = clr_idx_q + IDX_W'(1);
        if (clr_idx_q == IDX_W'(MAX_BLOCKS - 1)) begin
          state_d = BK_IDLE;
        end
      end
      BK_IDLE: begin
        mem_raddr = head_first;
        if (q_valid_i) begin
          unique case (q_cmd_i.cmd)
            CMD_READ, CMD_WRITE: begin
              cur_d   = head_first;
              state_d = BK_WALK;
            end
            CMD_QUERY: begin
              state_d = BK_QUERY;
            end
            CMD_REPORT: begin
              tot_rd_d = '0;
              tot_wr_d = '0;
              state_d  = BK_EMIT;
            end
            default: begin
              state_d = BK_IDLE;
            end
          endcase
        end
      end
      BK_WALK: begin
        // write this block back while the next one is read
        rd_we     = (q_cmd_i.cmd == CMD_READ);
        wr_we     = (q_cmd_i.cmd == CMD_WRITE);
        mem_raddr = cur_q + IDX_W'(1);
        if (cur_q == head_last) begin
          tot_rd_d = '0;
          tot_wr_d = '0;
          state_d  = BK_EMIT;
        end else begin
          cur_d = cur_q + IDX_W'(1);
        end
      end
      BK_QUERY: begin
        tot_rd_d = TOTAL_W'(rd_rdata_q);
        tot_wr_d = TOTAL_W'(wr_rdata_q);
        state_d  = BK_EMIT;
      end
      BK_EMIT: begin
        if (!out_valid_q || out_o.ready) begin
          load_out = 1'b1;
          q_pop_o  = 1'b1;
          state_d  = BK_IDLE;
        end
      end
      default: begin
        state_d = BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= BK_CLEAR;
      clr_idx_q <= '0;
      cur_q     <= '0;
    end else begin
      state_q   <= state_d;
      clr_idx_q <= clr_idx_d;
      cur_q     <= cur_d;
    end
  end

  always_ff @(posedge clk_i) begin
    tot_rd_q <= tot_rd_d;
    tot_wr_q <= tot_wr_d;
  end

  always_ff @(posedge clk_i) begin
    if (rd_we) begin
      rd_mem[mem_waddr] <= mem_wdata;
    end
    rd_rdata_q <= rd_mem[mem_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (wr_we) begin
      wr_mem[mem_waddr] <= mem_wdata;
    end
    wr_rdata_q <= wr_mem[mem_raddr];
  end

  // result register
  always_comb begin
    out_valid_d = out_valid_q;
    if (load_out) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_o.status         <= q_cmd_i.status;
      out_o.first_block    <= q_cmd_i.first_block;
      out_o.blocks_touched <= q_cmd_i.touched;
      out_o.read_total     <= tot_rd_q;
      out_o.write_total    <= tot_wr_q;
    end
  end

  assign out_o.valid = out_valid_q;

`ifndef NO_ASSERTIONS
  a_walk_one_store: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == BK_WALK |-> rd_we != wr_we)
    else $error("walk must update exactly one store");
  a_pop_needs_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop_o |-> q_valid_i)
    else $error("pop of empty queue");
  a_walk_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == BK_WALK |-> cur_q <= head_last)
    else $error("walk ran past last block");
  a_no_result_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == BK_CLEAR |-> !load_out && !q_pop_o)
    else $error("result produced during clearing");
  a_clear_ends_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(state_q == BK_CLEAR) && state_q != BK_CLEAR |-> state_q == BK_IDLE)
    else $error("clearing left to wrong state");
`endif

endmodule

// ===== hw/rtl/block_access_heat_counter.sv =====
// top level of the block access heat counter
//
//   channel   dir   handshake      beat carries
//   in_i      in    valid/ready    opcode, byte_offset, byte_length, query_block
//   out_o     out   valid/ready    status, first_block, blocks_touched, totals
//   cfg       in    cfg_we_i       chunk_bytes
//
// after reset both counter stores are cleared, one block per cycle, during which
// no input beat is taken (configuration writes are taken). an access walks its
// blocks, a query reads both stores, an access that touches nothing goes straight
// to the result; the walk does one read-modify-write per block.
// the front end checks the next item while the back end works; a two-entry
// queue and the result register let either side stall without losing a beat.
module block_access_heat_counter import bahc_pkg::*; #(
  parameter int BLOCK_BYTES_LOG2 = 12,
  parameter int MAX_BLOCKS       = 1024,
  parameter int COUNT_BITS       = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CHUNK_W-1:0] cfg_wdata_i,
  bahc_in_if.sink            in_i,
  bahc_out_if.source         out_o
);

  logic [CHUNK_W-1:0] chunk_bytes_q;
  logic               clear_busy;
  logic               push_valid;
  logic               push_ready;
  bahc_cmd_t          push_cmd;
  logic               pop_valid;
  bahc_cmd_t          pop_cmd;
  logic               pop;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chunk_bytes_q <= '0;
    end else if (cfg_we_i) begin
      chunk_bytes_q <= cfg_wdata_i;
    end
  end

  bahc_front #(
    .BLOCK_BYTES_LOG2 (BLOCK_BYTES_LOG2),
    .MAX_BLOCKS       (MAX_BLOCKS)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .chunk_bytes_i (chunk_bytes_q),
    .clear_busy_i  (clear_busy),
    .in_i          (in_i),
    .push_valid_o  (push_valid),
    .push_cmd_o    (push_cmd),
    .push_ready_i  (push_ready)
  );

  bahc_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_cmd_i   (push_cmd),
    .push_ready_o (push_ready),
    .pop_valid_o  (pop_valid),
    .pop_cmd_o    (pop_cmd),
    .pop_i        (pop)
  );

  bahc_back #(
    .MAX_BLOCKS (MAX_BLOCKS),
    .COUNT_BITS (COUNT_BITS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .q_valid_i    (pop_valid),
    .q_cmd_i      (pop_cmd),
    .q_pop_o      (pop),
    .clear_busy_o (clear_busy),
    .out_o        (out_o)
  );

endmodule
